@@ rtl/pixel_color_family_classifier_macros.svh @@
// Assertion macros shared by the pixel color family classifier RTL.
`ifndef PIXEL_COLOR_FAMILY_CLASSIFIER_MACROS_SVH
`define PIXEL_COLOR_FAMILY_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pccf assertion failed");

// Next-cycle implication, disabled during reset.
`define PCCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pccf assertion failed");

`endif

@@ rtl/pccf_pkg.sv @@
// Types and constants of the pixel color family classifier.
package pccf_pkg;

    localparam int SEL_W = 7;
    localparam logic [SEL_W-1:0] SEL_RESET = 7'h7F;

    typedef enum logic [2:0] {
        FAM_NONE   = 3'd0,
        FAM_RED    = 3'd1,
        FAM_BLUE   = 3'd2,
        FAM_YO     = 3'd3,
        FAM_GREEN  = 3'd4,
        FAM_BLACK  = 3'd5,
        FAM_WHITE  = 3'd6,
        FAM_SKIN   = 3'd7
    } family_t;

    // Q16 luma weights, summing to 65536
    localparam logic [23:0] LUMA_WR = 24'd13933;
    localparam logic [23:0] LUMA_WG = 24'd46871;
    localparam logic [23:0] LUMA_WB = 24'd4732;

    // Skin luma window on the full Q16 sum
    localparam logic [23:0] SKIN_LUMA_LO = 24'd95 << 16;
    localparam logic [23:0] SKIN_LUMA_HI = 24'd205 << 16;

endpackage

@@ rtl/pccf_pixel_if.sv @@
// Pixel request channel: valid/ready handshake with an RGB payload.
interface pccf_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/pccf_result_if.sv @@
// Result request channel: valid/ready handshake with the classification payload.
interface pccf_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  family;
    logic [2:0]  raw_family;
    logic        is_selected;
    logic [15:0] luma_q8;
    logic [7:0]  chroma;

    modport source (output valid, output family, output raw_family, output is_selected,
                    output luma_q8, output chroma, input ready);
    modport sink   (input valid, input family, input raw_family, input is_selected,
                    input luma_q8, input chroma, output ready);
endinterface

@@ rtl/pixel_color_family_classifier.sv @@
// Top level of the pixel color family classifier.
//
// Usage: pixels enter on the pixel channel (valid/ready, red/green/blue),
// one class result per pixel leaves on the result channel in order.
// The block has two register ranks: an input register and a result
// register, with max/min/chroma, the Q16 luma sum and the rule chain in
// between. An accepted pixel passes the input register and then the result
// register, which drives the result channel. Throughput is one pixel per
// cycle; the two ranks advance together whenever the result register is
// empty or being taken.
// When the receiver stalls, the result register holds; one more pixel
// can sit in the input register, then pixel.ready drops.
// Reset empties both ranks and sets sel_reg to all seven
// families. cfg_we writes cfg_wdata into sel_reg at the edge;
// write it only while no pixel is in flight.
`include "pixel_color_family_classifier_macros.svh"

module pixel_color_family_classifier (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pccf_pkg::SEL_W-1:0]   cfg_wdata,
    pccf_pixel_if.sink                   pixel,
    pccf_result_if.source                result
);
    import pccf_pkg::*;

    logic [SEL_W-1:0] sel_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_red_reg;
    logic [7:0] s1_green_reg;
    logic [7:0] s1_blue_reg;

    logic        out_valid_reg;
    family_t     out_family_reg;
    family_t     out_raw_reg;
    logic [15:0] out_luma_reg;
    logic [7:0]  out_chroma_reg;

    logic out_load;
    logic s1_load;

    logic [7:0]        hi;
    logic [7:0]        lo;
    logic [7:0]        ch;
    logic [23:0]       luma16;
    logic signed [9:0] rs;
    logic signed [9:0] gs;
    logic signed [9:0] bs;
    logic signed [9:0] his;
    logic signed [9:0] los;
    logic signed [9:0] chs;
    logic              skin_luma_ok;
    family_t           raw_next;
    family_t           family_next;
    logic [2:0]        mask_idx;

    // advance the result rank when it is empty or being taken
    assign out_load    = !out_valid_reg || result.ready;
    assign s1_load     = !s1_valid_reg || out_load;
    assign pixel.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= SEL_RESET;
        end
        else if (cfg_we)
        begin
            sel_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= pixel.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && pixel.valid)
        begin
            s1_red_reg   <= pixel.red;
            s1_green_reg <= pixel.green;
            s1_blue_reg  <= pixel.blue;
        end
        if (out_load && s1_valid_reg)
        begin
            out_family_reg <= family_next;
            out_raw_reg    <= raw_next;
            out_luma_reg   <= luma16[23:8];
            out_chroma_reg <= ch;
        end
    end

    always_comb
    begin
        hi = (s1_red_reg > s1_green_reg) ? s1_red_reg : s1_green_reg;
        if (s1_blue_reg > hi)
        begin
            hi = s1_blue_reg;
        end
        lo = (s1_red_reg < s1_green_reg) ? s1_red_reg : s1_green_reg;
        if (s1_blue_reg < lo)
        begin
            lo = s1_blue_reg;
        end
        ch = hi - lo;
    end

    assign luma16 = LUMA_WR * 24'(s1_red_reg) + LUMA_WG * 24'(s1_green_reg)
                  + LUMA_WB * 24'(s1_blue_reg);

    assign skin_luma_ok = (luma16 >= SKIN_LUMA_LO) && (luma16 <= SKIN_LUMA_HI);

    // signed copies so that offsets below zero compare as in integer math
    assign rs  = signed'({2'b00, s1_red_reg});
    assign gs  = signed'({2'b00, s1_green_reg});
    assign bs  = signed'({2'b00, s1_blue_reg});
    assign his = signed'({2'b00, hi});
    assign los = signed'({2'b00, lo});
    assign chs = signed'({2'b00, ch});

    // first rule that holds wins
    always_comb
    begin
        if (his <= 10'sd48 && chs <= 10'sd34)
        begin
            raw_next = FAM_BLACK;
        end
        else if (los >= 10'sd210 && chs <= 10'sd48)
        begin
            raw_next = FAM_WHITE;
        end
        else if (rs >= 10'sd120 && gs >= 10'sd70 && bs >= 10'sd45
                 && rs > gs + 10'sd28 && rs > bs + 10'sd48
                 && gs >= bs - 10'sd8 && gs <= rs - 10'sd18 && skin_luma_ok)
        begin
            raw_next = FAM_SKIN;
        end
        else if (rs >= 10'sd150 && gs >= 10'sd95 && bs <= 10'sd120
                 && rs >= gs - 10'sd15 && chs >= 10'sd70)
        begin
            raw_next = FAM_YO;
        end
        else if (rs >= 10'sd145 && rs > gs + 10'sd55 && rs > bs + 10'sd45
                 && gs <= 10'sd135 && chs >= 10'sd70)
        begin
            raw_next = FAM_RED;
        end
        else if (bs >= 10'sd120 && bs > rs + 10'sd45 && bs > gs + 10'sd35
                 && chs >= 10'sd65)
        begin
            raw_next = FAM_BLUE;
        end
        else if (gs >= 10'sd105 && gs > rs + 10'sd35 && gs > bs + 10'sd30
                 && chs >= 10'sd55)
        begin
            raw_next = FAM_GREEN;
        end
        else
        begin
            raw_next = FAM_NONE;
        end
    end

    // family code n is kept by mask bit n-1
    assign mask_idx = 3'(raw_next) - 3'd1;

    always_comb
    begin
        family_next = FAM_NONE;
        if (raw_next != FAM_NONE && sel_reg[mask_idx])
        begin
            family_next = raw_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.family      = out_family_reg;
    assign result.raw_family  = out_raw_reg;
    assign result.is_selected = (out_family_reg != FAM_NONE);
    assign result.luma_q8     = out_luma_reg;
    assign result.chroma      = out_chroma_reg;

    `PCCF_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, pixel.valid && pixel.ready, s1_valid_reg)
    `PCCF_ASSERT_NEXT(a_s1_moves_out, clk, rst_n, s1_valid_reg && out_load, out_valid_reg)
    `PCCF_ASSERT_NOW(a_family_is_raw, clk, rst_n,
        result.valid && result.family != FAM_NONE, result.family == result.raw_family)
    `PCCF_ASSERT_NOW(a_black_low_chroma, clk, rst_n,
        result.valid && result.raw_family == FAM_BLACK, result.chroma <= 8'd34)

endmodule
